### sv/bis_pkg.sv
// shared types, codes and helpers for the bitmap integer set
package bis_pkg;

    localparam int VAL_W     = 16;
    localparam int MODE_W    = 3;
    localparam int CFG_IDX_W = 1;
    localparam int BYTE_BITS = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX = 1'b1;

    localparam logic signed [VAL_W-1:0] MIN_RESET = 16'sd0;
    localparam logic signed [VAL_W-1:0] MAX_RESET = 16'sd2047;

    typedef enum logic [MODE_W-1:0] {
        MODE_ADD = 3'd0,
        MODE_REMOVE,
        MODE_CONTAINS,
        MODE_ADD_ALL,
        MODE_REMOVE_ALL,
        MODE_NEXT
    } t_mode;

    typedef enum logic [3:0] {
        S_CLR,
        S_IDLE,
        S_PREP,
        S_DIV,
        S_MUL,
        S_ACT,
        S_SCAN,
        S_FIND,
        S_FMUL,
        S_FCHK,
        S_FILL,
        S_DONE
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic prep;
        logic div;
        logic mul;
        logic wr_bit;
        logic res_bit;
        logic find_load;
        logic find_scan;
        logic find_shift;
        logic find_fin;
        logic fmul;
        logic fchk;
        logic scan_step;
        logic idx_clr;
        logic idx_inc;
        logic fill_wr;
        logic fill_ones;
        logic out_load;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              in_range;
        logic              gn_ok;
        logic              word_hit;
        logic              rdata_nz;
        logic              idx_last;
        logic              byte_zero;
    } t_dp_sts;

    // position of the lowest set bit of a byte
    function automatic logic [2:0] lsb_index8(input logic [BYTE_BITS-1:0] b);
        logic [2:0] idx;
        idx = 3'd0;
        for (int i = BYTE_BITS - 1; i >= 0; i--) begin
            if (b[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

endpackage

### sv/bis_ctrl.sv
// sequencing state machine for the bitmap integer set
module bis_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    input  logic             i_m_tready,
    output logic             o_m_tvalid,
    output bis_pkg::t_dp_cmd o_cmd,
    input  bis_pkg::t_dp_sts i_sts
);

    bis_pkg::t_state r_state;
    bis_pkg::t_state n_state;
    logic            r_m_tvalid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bis_pkg::S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    assign o_m_tvalid = r_m_tvalid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            bis_pkg::S_CLR: begin
                o_cmd.fill_wr = 1'b1;
                if (i_sts.idx_last) begin
                    n_state = bis_pkg::S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            bis_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = bis_pkg::S_PREP;
                end
            end
            bis_pkg::S_PREP: begin
                unique case (i_sts.mode) inside
                    bis_pkg::MODE_ADD_ALL, bis_pkg::MODE_REMOVE_ALL: begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = bis_pkg::S_FILL;
                    end
                    bis_pkg::MODE_ADD, bis_pkg::MODE_REMOVE, bis_pkg::MODE_CONTAINS,
                    bis_pkg::MODE_NEXT: begin
                        o_cmd.prep = 1'b1;
                        n_state    = bis_pkg::S_DIV;
                    end
                    default: begin
                        n_state = bis_pkg::S_DONE;
                    end
                endcase
            end
            bis_pkg::S_DIV: begin
                if ((i_sts.mode == bis_pkg::MODE_NEXT) ? i_sts.gn_ok : i_sts.in_range) begin
                    o_cmd.div = 1'b1;
                    n_state   = bis_pkg::S_MUL;
                end else begin
                    n_state = bis_pkg::S_DONE;
                end
            end
            bis_pkg::S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = bis_pkg::S_ACT;
            end
            bis_pkg::S_ACT: begin
                unique case (i_sts.mode) inside
                    bis_pkg::MODE_ADD, bis_pkg::MODE_REMOVE: begin
                        o_cmd.wr_bit = 1'b1;
                        n_state      = bis_pkg::S_DONE;
                    end
                    bis_pkg::MODE_CONTAINS: begin
                        o_cmd.res_bit = 1'b1;
                        n_state       = bis_pkg::S_DONE;
                    end
                    default: begin
                        if (i_sts.word_hit) begin
                            o_cmd.find_load = 1'b1;
                            n_state         = bis_pkg::S_FIND;
                        end else if (i_sts.idx_last) begin
                            n_state = bis_pkg::S_DONE;
                        end else begin
                            o_cmd.scan_step = 1'b1;
                            n_state         = bis_pkg::S_SCAN;
                        end
                    end
                endcase
            end
            bis_pkg::S_SCAN: begin
                if (i_sts.rdata_nz) begin
                    o_cmd.find_load = 1'b1;
                    o_cmd.find_scan = 1'b1;
                    n_state         = bis_pkg::S_FIND;
                end else if (i_sts.idx_last) begin
                    n_state = bis_pkg::S_DONE;
                end else begin
                    o_cmd.scan_step = 1'b1;
                end
            end
            bis_pkg::S_FIND: begin
                if (i_sts.byte_zero) begin
                    o_cmd.find_shift = 1'b1;
                end else begin
                    o_cmd.find_fin = 1'b1;
                    n_state        = bis_pkg::S_FMUL;
                end
            end
            bis_pkg::S_FMUL: begin
                o_cmd.fmul = 1'b1;
                n_state    = bis_pkg::S_FCHK;
            end
            bis_pkg::S_FCHK: begin
                o_cmd.fchk = 1'b1;
                n_state    = bis_pkg::S_DONE;
            end
            bis_pkg::S_FILL: begin
                o_cmd.fill_wr   = 1'b1;
                o_cmd.fill_ones = (i_sts.mode == bis_pkg::MODE_ADD_ALL);
                if (i_sts.idx_last) begin
                    n_state = bis_pkg::S_DONE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            bis_pkg::S_DONE: begin
                if (!r_m_tvalid || i_m_tready) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = bis_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = bis_pkg::S_IDLE;
            end
        endcase
    end

endmodule

### sv/bis_dp.sv
// bitmap memory, offset arithmetic, word scan and bit find
module bis_dp #(
    parameter int WORD_BITS = 32,
    parameter int NUM_WORDS = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bis_pkg::VAL_W-1:0]           i_cfg_data,
    input  logic [bis_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [bis_pkg::VAL_W-1:0]    i_value,
    input  bis_pkg::t_dp_cmd                    i_cmd,
    output bis_pkg::t_dp_sts                    o_sts,
    output logic                                o_hit,
    output logic signed [bis_pkg::VAL_W-1:0]    o_next_value
);

    localparam int CAP    = WORD_BITS * NUM_WORDS;
    localparam int CAP_W  = $clog2(CAP) + 1;
    localparam int BIT_W  = $clog2(WORD_BITS);
    localparam int IDX_W  = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int EXT_W  = ((CAP_W > bis_pkg::VAL_W) ? CAP_W : bis_pkg::VAL_W) + 2;
    localparam int SHIFT  = CAP_W + BIT_W;
    localparam int REC_W  = CAP_W + 2;
    localparam int PROD_W = CAP_W + REC_W;
    localparam longint RECIP = ((longint'(1) << SHIFT) + WORD_BITS - 1) / WORD_BITS;

    localparam logic [REC_W-1:0]        RECIP_C  = REC_W'(RECIP);
    localparam logic [CAP_W-1:0]        WB_C     = CAP_W'(WORD_BITS);
    localparam logic signed [EXT_W-1:0] CAP_TOP  = EXT_W'(CAP - 1);
    localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(NUM_WORDS - 1);

    // configuration and derived bound
    logic signed [bis_pkg::VAL_W-1:0] r_min;
    logic signed [bis_pkg::VAL_W-1:0] r_max;
    logic signed [EXT_W-1:0]          r_emax;

    // request
    logic [bis_pkg::MODE_W-1:0]       r_mode;
    logic signed [bis_pkg::VAL_W-1:0] r_val;
    logic [CAP_W-1:0]                 r_off;
    logic                             r_inr;
    logic                             r_gn_ok;

    // word position and find
    logic [IDX_W-1:0]     r_idx;
    logic [BIT_W-1:0]     r_bit;
    logic [WORD_BITS-1:0] r_word;
    logic [BIT_W-1:0]     r_b;
    logic [CAP_W-1:0]     r_pos;

    // result and output
    logic                             r_res_hit;
    logic signed [bis_pkg::VAL_W-1:0] r_res_val;
    logic                             r_out_hit;
    logic signed [bis_pkg::VAL_W-1:0] r_out_val;

    // bitmap
    logic [WORD_BITS-1:0] r_mem [NUM_WORDS];
    logic [WORD_BITS-1:0] r_rdata;

    logic signed [EXT_W-1:0] w_min_x;
    logic signed [EXT_W-1:0] w_max_x;
    logic signed [EXT_W-1:0] w_val_x;
    logic signed [EXT_W-1:0] w_cap_top;
    logic signed [EXT_W-1:0] w_off_v;
    logic signed [EXT_W-1:0] w_off_n;
    logic signed [EXT_W-1:0] w_found;
    logic                    w_lt_min;
    logic [PROD_W-1:0]       w_prod;
    logic [IDX_W-1:0]        w_rd_addr;
    logic [WORD_BITS-1:0]    w_mask;
    logic [WORD_BITS-1:0]    w_wr_data;
    logic                    w_we;
    logic [BIT_W-1:0]        w_sh_amt;

    always_comb begin
        w_min_x   = EXT_W'(r_min);
        w_max_x   = EXT_W'(r_max);
        w_val_x   = EXT_W'(r_val);
        w_cap_top = w_min_x + CAP_TOP;
        w_lt_min  = (w_val_x < w_min_x);
        w_off_v   = w_val_x - w_min_x;
        w_off_n   = w_lt_min ? '0 : (w_off_v + EXT_W'(1));
        w_prod    = PROD_W'(r_off) * PROD_W'(RECIP_C);
        w_found   = w_min_x + $signed(EXT_W'(r_pos));
        w_sh_amt  = i_cmd.find_scan ? '0 : r_bit;
        w_rd_addr = i_cmd.scan_step ? (r_idx + IDX_W'(1)) : r_idx;
        w_mask    = {{(WORD_BITS - 1){1'b0}}, 1'b1} << r_bit;
        w_we      = i_cmd.fill_wr | i_cmd.wr_bit;
        if (i_cmd.fill_wr) begin
            w_wr_data = i_cmd.fill_ones ? '1 : '0;
        end else if (r_mode == bis_pkg::MODE_ADD) begin
            w_wr_data = r_rdata | w_mask;
        end else begin
            w_wr_data = r_rdata & ~w_mask;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= bis_pkg::MIN_RESET;
            r_max <= bis_pkg::MAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                bis_pkg::CFG_MIN: r_min <= $signed(i_cfg_data);
                bis_pkg::CFG_MAX: r_max <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    // maximum saturated to the capacity above the minimum
    always_ff @(posedge i_clk) begin
        r_emax <= (w_max_x > w_cap_top) ? w_cap_top : w_max_x;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_val  <= i_value;
        end
        if (i_cmd.prep) begin
            r_off   <= (r_mode == bis_pkg::MODE_NEXT) ? CAP_W'(w_off_n) : CAP_W'(w_off_v);
            r_inr   <= !w_lt_min && (w_val_x <= r_emax);
            r_gn_ok <= (w_val_x < r_emax);
        end
        if (i_cmd.mul) begin
            r_bit <= BIT_W'(r_off - CAP_W'(r_idx) * WB_C);
        end
        if (i_cmd.fmul) begin
            r_pos <= CAP_W'(r_idx) * WB_C + CAP_W'(r_b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_cmd.div) begin
            r_idx <= w_prod[SHIFT +: IDX_W];
        end else if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.scan_step || i_cmd.idx_inc) begin
            r_idx <= r_idx + IDX_W'(1);
        end
    end

    // bit find, one byte a cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.find_load) begin
            r_word <= r_rdata >> w_sh_amt;
            r_b    <= w_sh_amt;
        end else if (i_cmd.find_shift) begin
            r_word <= r_word >> bis_pkg::BYTE_BITS;
            r_b    <= r_b + BIT_W'(bis_pkg::BYTE_BITS);
        end else if (i_cmd.find_fin) begin
            r_b <= r_b + BIT_W'(bis_pkg::lsb_index8(r_word[bis_pkg::BYTE_BITS-1:0]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_res_hit <= 1'b0;
            r_res_val <= i_value;
        end else if (i_cmd.res_bit) begin
            r_res_hit <= r_rdata[r_bit];
        end else if (i_cmd.fchk && (w_found <= r_emax)) begin
            r_res_hit <= 1'b1;
            r_res_val <= w_found[bis_pkg::VAL_W-1:0];
        end
        if (i_cmd.out_load) begin
            r_out_hit <= r_res_hit;
            r_out_val <= r_res_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_idx] <= w_wr_data;
        end
        r_rdata <= r_mem[w_rd_addr];
    end

    always_comb begin
        o_sts.mode      = r_mode;
        o_sts.in_range  = r_inr;
        o_sts.gn_ok     = r_gn_ok;
        o_sts.word_hit  = |(r_rdata >> r_bit);
        o_sts.rdata_nz  = |r_rdata;
        o_sts.idx_last  = (r_idx == LAST_IDX);
        o_sts.byte_zero = (r_word[bis_pkg::BYTE_BITS-1:0] == '0);
    end

    assign o_hit        = r_out_hit;
    assign o_next_value = r_out_val;

endmodule

### sv/bitmap_integer_set_core.sv
// top level of the bitmap integer set: stream ports, config port, controller and datapath
//
// Holds a set of integers from min_value to max_value (max saturated to
// min_value + WORD_BITS*NUM_WORDS - 1) as NUM_WORDS words of WORD_BITS bits
// in a single-port memory. Each request on the slave stream carries a mode in
// tuser and a value in tdata and gives exactly one transaction on the master
// stream: hit in tuser, next member (or the request value echoed) in tdata.
// One request is in work at a time. Add, remove and contains pass through the
// prep, divide, multiply and act steps before the result is loaded; unused
// modes end after prep and out of range values after the range check. Add
// all and remove all rewrite the memory one word a cycle. Get next scans
// the bitmap from the start word, one word per cycle from the memory port,
// and then finds the bit, stepping one byte a cycle. After reset a clearing
// pass writes zeros to all NUM_WORDS words while s_axis_tready stays low;
// config writes are taken throughout. min_value and max_value should be
// written only while no request is in work.
module bitmap_integer_set_core #(
    parameter int WORD_BITS = 32,
    parameter int NUM_WORDS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // slave stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [15:0]                   s_axis_tdata,   // [15:0] value
    input  logic [7:0]                    s_axis_tuser,   // [2:0] mode, rest zero
    // master stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata,   // [15:0] next_value
    output logic [7:0]                    m_axis_tuser,   // [0] hit, rest zero
    // config write port
    input  logic                          i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0] i_cfg_idx,      // 0 min_value, 1 max_value
    input  logic [bis_pkg::VAL_W-1:0]     i_cfg_data
);

    bis_pkg::t_dp_cmd                 w_cmd;
    bis_pkg::t_dp_sts                 w_sts;
    logic                             w_hit;
    logic signed [bis_pkg::VAL_W-1:0] w_next_value;

    // sequencing: clearing pass, request steps, output hand-off
    bis_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .o_cmd      (w_cmd),
        .i_sts      (w_sts)
    );

    // bitmap memory and arithmetic
    bis_dp #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_mode       (s_axis_tuser[bis_pkg::MODE_W-1:0]),
        .i_value      ($signed(s_axis_tdata)),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .o_hit        (w_hit),
        .o_next_value (w_next_value)
    );

    assign m_axis_tdata = w_next_value;
    assign m_axis_tuser = {7'b0, w_hit};

    // one request at a time: no back-to-back acceptance
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second transaction accepted while a request is in work");

    // the scan never steps past the last bitmap word
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.scan_step |-> !w_sts.idx_last)
        else $error("word scan stepped beyond the last word");

    // a result is never loaded over one still waiting
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
        else $error("result register overwritten while still waiting");

    // a loaded result is presented on the next cycle
    a_out_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |=> m_axis_tvalid)
        else $error("loaded result not presented");

endmodule

### verif/bitmap_integer_set_core_test.sv
// self-checking testbench for the bitmap integer set core
`timescale 1ns / 1ps

module bitmap_integer_set_core_test;

    localparam int WORD_BITS     = 32;
    localparam int NUM_WORDS     = 64;
    localparam int CAPACITY      = WORD_BITS * NUM_WORDS;
    localparam int RESET_CYCLES  = 7;
    localparam int SETTLE_CYCLES = 8;        // block back in idle after its last result
    localparam int DRAIN_LIMIT   = 200000;
    localparam int REPORT_LIMIT  = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_BLOCKS = 8;
    localparam int ITEMS_PER_BLOCK = 52;

    // modes the block does not define: it must leave the set alone and echo the value
    localparam logic [bis_pkg::MODE_W-1:0] MODE_SPARE_LO = 3'd6;
    localparam logic [bis_pkg::MODE_W-1:0] MODE_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                      hit;
        logic [bis_pkg::VAL_W-1:0] next_value;
    } t_set_reply;

    logic              i_clk;
    logic              i_rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [15:0]       s_axis_tdata;   // [15:0] value
    logic [7:0]        s_axis_tuser;   // [2:0] mode, rest zero
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [15:0]       m_axis_tdata;   // [15:0] next_value
    logic [7:0]        m_axis_tuser;   // [0] hit, rest zero
    logic              i_cfg_we;
    logic [bis_pkg::CFG_IDX_W-1:0] i_cfg_idx;
    logic [bis_pkg::VAL_W-1:0]     i_cfg_data;

    // shadow copy of the set and its bounds
    logic [WORD_BITS-1:0]             member_words [NUM_WORDS];
    logic signed [bis_pkg::VAL_W-1:0] bound_min;
    logic signed [bis_pkg::VAL_W-1:0] bound_max;

    t_set_reply pending_replies [$];
    int         mismatches;
    int         send_idle_pct;
    int         stall_pct;
    int         hold_left;

    bitmap_integer_set_core #(
        .WORD_BITS (WORD_BITS),
        .NUM_WORDS (NUM_WORDS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    // apply one request to the shadow set and work out the reply it gives
    function automatic t_set_reply apply_set_request(
        input logic [bis_pkg::MODE_W-1:0]        mode,
        input logic signed [bis_pkg::VAL_W-1:0] operand);
        int         v;
        int         lo;
        int         emax;
        int         off;
        int         found;
        int         w;
        bit         in_rng;
        bit         seen;
        t_set_reply reply;
        v    = operand;
        lo   = bound_min;
        // maximum saturates to the top of the bitmap
        emax = (int'(bound_max) > lo + CAPACITY - 1) ? lo + CAPACITY - 1 : int'(bound_max);
        in_rng = (v >= lo) && (v <= emax);
        off    = v - lo;
        reply.hit        = 1'b0;
        reply.next_value = operand;
        case (mode)
            bis_pkg::MODE_ADD: begin
                if (in_rng) member_words[off / WORD_BITS][off % WORD_BITS] = 1'b1;
            end
            bis_pkg::MODE_REMOVE: begin
                if (in_rng) member_words[off / WORD_BITS][off % WORD_BITS] = 1'b0;
            end
            bis_pkg::MODE_CONTAINS: begin
                if (in_rng) reply.hit = member_words[off / WORD_BITS][off % WORD_BITS];
            end
            bis_pkg::MODE_ADD_ALL: begin
                // bits past the maximum get set too, they are just never reported
                for (w = 0; w < NUM_WORDS; w++) member_words[w] = '1;
            end
            bis_pkg::MODE_REMOVE_ALL: begin
                for (w = 0; w < NUM_WORDS; w++) member_words[w] = '0;
            end
            bis_pkg::MODE_NEXT: begin
                if (v < emax) begin
                    seen  = 1'b0;
                    found = 0;
                    // search from the minimum when the start point lies below it
                    for (off = (v < lo) ? 0 : v + 1 - lo; off < CAPACITY && !seen; off++) begin
                        if (member_words[off / WORD_BITS][off % WORD_BITS]) begin
                            seen  = 1'b1;
                            found = lo + off;
                        end
                    end
                    // a member beyond the maximum counts as not found
                    if (seen && found <= emax) begin
                        reply.hit        = 1'b1;
                        reply.next_value = found[bis_pkg::VAL_W-1:0];
                    end
                end
            end
            default: ;
        endcase
        return reply;
    endfunction

    task automatic flag_mismatch(input string detail);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("mismatch: %0s", detail);
    endtask

    // one request transaction on the slave stream, with random idle cycles first
    task automatic send_item(input logic [bis_pkg::MODE_W-1:0] mode, input int value);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value[15:0];
        s_axis_tuser  <= {5'b0, mode};
        do @(posedge i_clk); while (!s_axis_tready);
        pending_replies.push_back(apply_set_request(mode, value[15:0]));
    endtask

    // stop offering and wait until every reply is in and the block is idle
    task automatic wait_drain();
        int guard;
        guard = 0;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_replies.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg(input logic [bis_pkg::CFG_IDX_W-1:0] idx, input int value);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value[15:0];
        if (idx == bis_pkg::CFG_MIN) bound_min = value[15:0];
        else                         bound_max = value[15:0];
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_bounds(input int lo, input int hi);
        wait_drain();
        write_cfg(bis_pkg::CFG_MIN, lo);
        write_cfg(bis_pkg::CFG_MAX, hi);
    endtask

    // reset bounds: edges of the range, out of range values, spare modes
    task automatic test_default_bounds();
        send_item(bis_pkg::MODE_CONTAINS, 0);
        send_item(bis_pkg::MODE_ADD, 0);
        send_item(bis_pkg::MODE_ADD, 2047);
        send_item(bis_pkg::MODE_ADD, 2048);
        send_item(bis_pkg::MODE_ADD, -1);
        send_item(bis_pkg::MODE_CONTAINS, 2047);
        send_item(bis_pkg::MODE_CONTAINS, 2048);
        send_item(bis_pkg::MODE_NEXT, -32768);
        send_item(bis_pkg::MODE_NEXT, 0);
        send_item(bis_pkg::MODE_NEXT, 2047);
        send_item(bis_pkg::MODE_REMOVE, 0);
        send_item(bis_pkg::MODE_CONTAINS, 0);
        send_item(MODE_SPARE_LO, 32768);
        send_item(MODE_SPARE_HI, 32767);
    endtask

    // bound changes over a kept bitmap, saturation, empty range, top of the value range
    task automatic test_bound_changes();
        wait_drain();
        write_cfg(bis_pkg::CFG_MAX, 100);
        send_item(bis_pkg::MODE_NEXT, 50);          // only member lies past the new maximum
        send_item(bis_pkg::MODE_ADD_ALL, 0);
        send_item(bis_pkg::MODE_NEXT, 99);
        send_item(bis_pkg::MODE_REMOVE_ALL, 0);
        send_item(bis_pkg::MODE_NEXT, -1);          // nothing left to find
        set_bounds(-32768, 32767);                  // maximum saturates to the bitmap top
        send_item(bis_pkg::MODE_ADD, -30721);
        send_item(bis_pkg::MODE_NEXT, -32768);
        send_item(bis_pkg::MODE_ADD, -30720);
        set_bounds(100, 50);                        // maximum below minimum
        send_item(bis_pkg::MODE_ADD, 75);
        send_item(bis_pkg::MODE_CONTAINS, 75);
        send_item(bis_pkg::MODE_NEXT, 10);
        set_bounds(32767, 32767);
        send_item(bis_pkg::MODE_ADD, 32767);
        send_item(bis_pkg::MODE_CONTAINS, 32767);
    endtask

    // receiver holds off while the sender keeps offering, then the sender pauses
    task automatic test_backpressure();
        int i;
        set_bounds(0, 63);
        send_idle_pct = 0;
        stall_pct     = 0;
        send_item(bis_pkg::MODE_ADD, 7);
        hold_left = HOLD_CYCLES;
        for (i = 0; i < 10; i++) begin
            case ($urandom_range(2))
                0:       send_item(bis_pkg::MODE_ADD, $urandom_range(0, 63));
                1:       send_item(bis_pkg::MODE_CONTAINS, $urandom_range(0, 63));
                default: send_item(bis_pkg::MODE_NEXT, $urandom_range(0, 63));
            endcase
        end
        wait_drain();
        send_item(bis_pkg::MODE_NEXT, 0);
        send_item(bis_pkg::MODE_CONTAINS, 7);
    endtask

    // random traffic over several bound settings and idle patterns
    task automatic test_random_traffic();
        int blk;
        int n;
        int lo;
        int hi;
        int emax;
        int r;
        int value;
        logic [bis_pkg::MODE_W-1:0] mode;
        for (blk = 0; blk < RANDOM_BLOCKS; blk++) begin
            case (blk)
                0: set_bounds(-32768, 32767);
                RANDOM_BLOCKS - 1: set_bounds(32767, -32768);
                default: begin
                    lo = int'($urandom_range(0, 65535)) - 32768;
                    case ($urandom_range(3))
                        0:       hi = lo + int'($urandom_range(0, 300));
                        1:       hi = lo + CAPACITY - 1;
                        2:       hi = lo - int'($urandom_range(1, 500));
                        default: hi = int'($urandom_range(0, 65535)) - 32768;
                    endcase
                    if (hi > 32767)  hi = 32767;
                    if (hi < -32768) hi = -32768;
                    set_bounds(lo, hi);
                end
            endcase
            // none, sender idle, receiver stall, both
            case (blk / 2)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 66; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 66; end
                default: begin send_idle_pct = 27; stall_pct = 27; end
            endcase
            lo   = bound_min;
            emax = (int'(bound_max) > lo + CAPACITY - 1) ? lo + CAPACITY - 1 : int'(bound_max);
            for (n = 0; n < ITEMS_PER_BLOCK; n++) begin
                r = $urandom_range(99);
                if (r < 30)      mode = bis_pkg::MODE_ADD;
                else if (r < 45) mode = bis_pkg::MODE_REMOVE;
                else if (r < 65) mode = bis_pkg::MODE_CONTAINS;
                else if (r < 90) mode = bis_pkg::MODE_NEXT;
                else if (r < 93) mode = bis_pkg::MODE_ADD_ALL;
                else if (r < 96) mode = bis_pkg::MODE_REMOVE_ALL;
                else             mode = ($urandom_range(1)) ? MODE_SPARE_HI : MODE_SPARE_LO;
                r = $urandom_range(99);
                if (r < 70 && emax >= lo) begin
                    value = lo + int'($urandom_range(0, emax - lo));
                end else if (r < 80) begin
                    case ($urandom_range(3))
                        0:       value = lo - 1;
                        1:       value = lo;
                        2:       value = emax;
                        default: value = emax + 1;
                    endcase
                end else begin
                    value = $urandom_range(0, 65535);
                end
                send_item(mode, value);
            end
        end
    endtask

    // receiver: random stalls, or a counted hold-off when one is requested
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // compare each reply transaction with the oldest expected reply
    always @(posedge i_clk) begin
        t_set_reply exp_reply;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_replies.size() == 0) begin
                flag_mismatch($sformatf("reply with no request, hit %0b next_value %0d",
                                        m_axis_tuser[0], $signed(m_axis_tdata)));
            end else begin
                exp_reply = pending_replies.pop_front();
                if (m_axis_tuser[0] !== exp_reply.hit)
                    flag_mismatch($sformatf("hit expected %0b, actual %0b",
                                            exp_reply.hit, m_axis_tuser[0]));
                if (m_axis_tdata !== exp_reply.next_value)
                    flag_mismatch($sformatf("next_value expected %0d, actual %0d",
                                            $signed(exp_reply.next_value),
                                            $signed(m_axis_tdata)));
            end
        end
    end

    initial begin
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = bis_pkg::CFG_MIN;
        i_cfg_data    = '0;
        i_rst_n       = 1'b0;
        mismatches    = 0;
        send_idle_pct = 0;
        stall_pct     = 0;
        hold_left     = 0;
        bound_min     = bis_pkg::MIN_RESET;
        bound_max     = bis_pkg::MAX_RESET;
        for (int w = 0; w < NUM_WORDS; w++) member_words[w] = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // clearing pass after reset is covered by waiting on tready
        test_default_bounds();
        test_bound_changes();
        test_backpressure();
        test_random_traffic();

        wait_drain();
        if (pending_replies.size() != 0)
            flag_mismatch($sformatf("%0d replies never arrived", pending_replies.size()));
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #4ms;
        $display("tb: failure");
        $finish;
    end

endmodule
